FILE: hw/rtl/hps_pkg.sv
// shared types and constants for the hartley power spectrum block
// no dependencies
`default_nettype none

package hps_pkg;

    localparam int unsigned MAX_WIDTH  = 256;
    localparam int unsigned MAX_HEIGHT = 256;
    localparam int unsigned IDX_W   = 8;
    localparam int unsigned SIZE_W  = 9;
    localparam int unsigned COEF_W  = 32;
    localparam int unsigned POWER_W = 63;
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = 2;
    localparam int unsigned Q_CNT_W = 3;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } hps_op_t;

    typedef enum logic {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } hps_cfg_idx_t;

    // one classified item between front and back
    typedef struct packed {
        hps_op_t                  op;
        logic                     bad;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic [SIZE_W-1:0]        mrow;
        logic [SIZE_W-1:0]        mcol;
        logic signed [COEF_W-1:0] coef;
    } hps_cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/hps_fifo.sv
// short command queue between front and back
// depends on hps_pkg
`default_nettype none

module hps_fifo (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  hps_pkg::hps_cmd_t     push_cmd,
    output logic                  full,
    input  wire logic             pop,
    output hps_pkg::hps_cmd_t     pop_cmd,
    output logic                  not_empty
);

    hps_pkg::hps_cmd_t                 entry_reg [hps_pkg::Q_DEPTH];
    logic [hps_pkg::Q_PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [hps_pkg::Q_PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [hps_pkg::Q_CNT_W-1:0]       count_reg, count_next;

    assign full      = (count_reg == hps_pkg::Q_CNT_W'(hps_pkg::Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/hps_front.sv
// front end: size registers, range check and mirror index computation
// depends on hps_pkg
`default_nettype none

module hps_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    input  wire logic                          cfg_index,
    input  wire logic [hps_pkg::SIZE_W-1:0]    cfg_data,
    input  wire logic                          in_valid,
    input  wire logic                          in_op,
    input  wire logic [hps_pkg::IDX_W-1:0]     in_row,
    input  wire logic [hps_pkg::IDX_W-1:0]     in_col,
    input  wire logic [hps_pkg::COEF_W-1:0]    in_coef,
    output logic                               push,
    output hps_pkg::hps_cmd_t                  push_cmd
);

    logic [hps_pkg::SIZE_W-1:0] width_reg, height_reg;
    logic [hps_pkg::SIZE_W-1:0] width_eff, height_eff;
    logic                       bad;

    function automatic logic [hps_pkg::SIZE_W-1:0] clamp_size(
        input logic [hps_pkg::SIZE_W-1:0] v,
        input int unsigned                maxv
    );
        logic [hps_pkg::SIZE_W-1:0] r;
        if (v == '0) begin
            r = hps_pkg::SIZE_W'(1);
        end else if (32'(v) > maxv) begin
            r = hps_pkg::SIZE_W'(maxv);
        end else begin
            r = v;
        end
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= hps_pkg::SIZE_W'(256);
            height_reg <= hps_pkg::SIZE_W'(256);
        end else if (cfg_valid) begin
            case (hps_pkg::hps_cfg_idx_t'(cfg_index))
                hps_pkg::CFG_FRAME_WIDTH:  width_reg  <= cfg_data;
                hps_pkg::CFG_FRAME_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        width_eff  = clamp_size(width_reg, hps_pkg::MAX_WIDTH);
        height_eff = clamp_size(height_reg, hps_pkg::MAX_HEIGHT);
        bad = ({1'b0, in_row} >= height_eff) || ({1'b0, in_col} >= width_eff);

        push_cmd.op   = hps_pkg::hps_op_t'(in_op);
        push_cmd.bad  = bad;
        push_cmd.row  = in_row;
        push_cmd.col  = in_col;
        push_cmd.mrow = (in_row == '0) ? '0 : height_eff - {1'b0, in_row};
        push_cmd.mcol = (in_col == '0) ? '0 : width_eff - {1'b0, in_col};
        push_cmd.coef = in_coef;

        // out-of-range loads are dropped here
        push = in_valid && !(bad && (push_cmd.op == hps_pkg::OP_LOAD));
    end

endmodule

`default_nettype wire

FILE: hw/rtl/hps_back.sv
// back end: coefficient frame store, squares, sum and output register
// depends on hps_pkg
`default_nettype none

module hps_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cmd_valid,
    input  hps_pkg::hps_cmd_t                  cmd,
    output logic                               cmd_pop,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [hps_pkg::POWER_W-1:0]        out_power,
    output logic                               out_error
);

    localparam int unsigned DEPTH = hps_pkg::MAX_WIDTH * hps_pkg::MAX_HEIGHT;
    localparam int unsigned AW    = $clog2(DEPTH);

    logic [hps_pkg::COEF_W-1:0]  store_mem [DEPTH];

    logic                        advance;
    logic                        is_load;
    logic [AW-1:0]               addr_a, addr_b;

    logic [hps_pkg::COEF_W-1:0]  rd_a_reg, rd_b_reg;
    logic                        s1_valid_reg, s1_bad_reg;
    logic [hps_pkg::COEF_W-1:0]  mag_a, mag_b;
    logic [2*hps_pkg::COEF_W-1:0] prod_a, prod_b;
    logic [hps_pkg::POWER_W-1:0] sq_a_reg, sq_b_reg;
    logic                        s2_valid_reg, s2_bad_reg;
    logic [hps_pkg::POWER_W:0]   sum;
    logic                        out_valid_reg;
    logic [hps_pkg::POWER_W-1:0] power_reg;
    logic                        error_reg;

    function automatic logic [hps_pkg::COEF_W-1:0] magnitude(
        input logic [hps_pkg::COEF_W-1:0] w
    );
        return w[hps_pkg::COEF_W-1] ? (~w + 1'b1) : w;
    endfunction

    always_comb begin
        advance = !out_valid_reg || out_ready;
        cmd_pop = cmd_valid && advance;
        is_load = (cmd.op == hps_pkg::OP_LOAD);
        addr_a  = AW'(32'(cmd.row) * hps_pkg::MAX_WIDTH + 32'(cmd.col));
        addr_b  = AW'(32'(cmd.mrow) * hps_pkg::MAX_WIDTH + 32'(cmd.mcol));
    end

    always_ff @(posedge aclk) begin
        if (cmd_pop && is_load) begin
            store_mem[addr_a] <= cmd.coef;
        end
        if (advance) begin
            rd_a_reg <= store_mem[addr_a];
            rd_b_reg <= store_mem[addr_b];
        end
    end

    always_comb begin
        mag_a  = magnitude(rd_a_reg);
        mag_b  = magnitude(rd_b_reg);
        prod_a = (2*hps_pkg::COEF_W)'(mag_a) * (2*hps_pkg::COEF_W)'(mag_a);
        prod_b = (2*hps_pkg::COEF_W)'(mag_b) * (2*hps_pkg::COEF_W)'(mag_b);
        sum    = (hps_pkg::POWER_W + 1)'(sq_a_reg) + (hps_pkg::POWER_W + 1)'(sq_b_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg  <= cmd_pop && !is_load;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_bad_reg <= cmd.bad;
            s2_bad_reg <= s1_bad_reg;
            sq_a_reg   <= prod_a[hps_pkg::POWER_W-1:0];
            sq_b_reg   <= prod_b[hps_pkg::POWER_W-1:0];
            error_reg  <= s2_bad_reg;
            power_reg  <= s2_bad_reg ? '0 : sum[hps_pkg::POWER_W:1];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_power = power_reg;
    assign out_error = error_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/hartley_power_spectrum_top.sv
// hartley power spectrum: load coefficients into a frame store, query power
// query path: queue, frame store read registers, square registers, output register
// throughput: one item per cycle unless m_tready stalls; single write/dual read store
// in-range loads and out-of-range queries use the same pipeline slot as other items
// reset: synchronous active-low; clears queue and valid flags, sizes return to 256
// frame store contents are not cleared and hold no value until loaded
`default_nettype none

module hartley_power_spectrum_top (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic                       cfg_index,
    input  wire logic [hps_pkg::SIZE_W-1:0] cfg_data,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [47:0]                s_tdata,   // row_index, col_index, coefficient
    input  wire logic                       s_tuser,   // operation
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [63:0]                     m_tdata,   // power, zero pad
    output logic                            m_tuser    // index_error
);

    logic                        q_full;
    logic                        q_not_empty;
    logic                        front_push;
    logic                        back_pop;
    hps_pkg::hps_cmd_t           front_cmd;
    hps_pkg::hps_cmd_t           back_cmd;
    logic [hps_pkg::POWER_W-1:0] power;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;

    hps_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid && !q_full),
        .in_op     (s_tuser),
        .in_row    (s_tdata[7:0]),
        .in_col    (s_tdata[15:8]),
        .in_coef   (s_tdata[47:16]),
        .push      (front_push),
        .push_cmd  (front_cmd)
    );

    hps_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (front_push),
        .push_cmd  (front_cmd),
        .full      (q_full),
        .pop       (back_pop),
        .pop_cmd   (back_cmd),
        .not_empty (q_not_empty)
    );

    hps_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_not_empty),
        .cmd       (back_cmd),
        .cmd_pop   (back_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_power (power),
        .out_error (m_tuser)
    );

    assign m_tdata = {1'b0, power};

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// self-checking testbench for hartley_power_spectrum_top: directed table, then random
// load/query traffic checked against a behavioral power predictor
// depends on hw/rtl/hps_pkg.sv and hw/rtl/hartley_power_spectrum_top.sv
`default_nettype none

module tb_top;
    import hps_pkg::*;

    localparam int unsigned FRAME_MAX    = 256;
    localparam int unsigned RANDOM_ITEMS = 500;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [POWER_W-1:0] power;
        logic               index_error;
    } spectrum_t;

    typedef enum logic [1:0] {
        ROW_LOAD,
        ROW_QUERY,
        ROW_CHECK,
        ROW_SIZE
    } row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        hps_cfg_idx_t       reg_sel;
        logic [SIZE_W-1:0]  size;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [COEF_W-1:0]  coef;
        logic [POWER_W-1:0] power;
        logic               index_error;
    } stim_row_t;

    localparam int unsigned N_DIRECTED = 29;
    localparam stim_row_t DIRECTED [0:N_DIRECTED-1] = '{
        '{ROW_LOAD,  CFG_FRAME_WIDTH,  9'd0,   8'd0,   8'd0,   32'h8000_0000, 63'd0, 1'b0},
        '{ROW_CHECK, CFG_FRAME_WIDTH,  9'd0,   8'd0,   8'd0,   32'h0, 63'h4000_0000_0000_0000, 1'b0},
        '{ROW_LOAD,  CFG_FRAME_WIDTH,  9'd0,   8'd0,   8'd0,   32'h7FFF_FFFF, 63'd0, 1'b0},
        '{ROW_CHECK, CFG_FRAME_WIDTH,  9'd0,   8'd0,   8'd0,   32'h0, 63'h3FFF_FFFF_0000_0001, 1'b0},
        '{ROW_LOAD,  CFG_FRAME_WIDTH,  9'd0,   8'd255, 8'd255, 32'hFFFF_FFFF, 63'd0, 1'b0},
        '{ROW_LOAD,  CFG_FRAME_WIDTH,  9'd0,   8'd1,   8'd1,   32'd3,         63'd0, 1'b0},
        '{ROW_CHECK, CFG_FRAME_WIDTH,  9'd0,   8'd1,   8'd1,   32'h0,         63'd5, 1'b0},
        '{ROW_CHECK, CFG_FRAME_WIDTH,  9'd0,   8'd255, 8'd255, 32'h0,         63'd5, 1'b0},
        '{ROW_LOAD,  CFG_FRAME_WIDTH,  9'd0,   8'd0,   8'd5,   32'd7,         63'd0, 1'b0},
        '{ROW_LOAD,  CFG_FRAME_WIDTH,  9'd0,   8'd0,   8'd251, 32'hFFFF_FFFE, 63'd0, 1'b0},
        '{ROW_CHECK, CFG_FRAME_WIDTH,  9'd0,   8'd0,   8'd5,   32'h0,         63'd26, 1'b0},
        '{ROW_LOAD,  CFG_FRAME_WIDTH,  9'd0,   8'd128, 8'd128, 32'h8000_0000, 63'd0, 1'b0},
        '{ROW_CHECK, CFG_FRAME_WIDTH,  9'd0,   8'd128, 8'd128, 32'h0, 63'h4000_0000_0000_0000, 1'b0},
        '{ROW_SIZE,  CFG_FRAME_WIDTH,  9'd0,   8'd0,   8'd0,   32'h0,         63'd0, 1'b0},
        '{ROW_SIZE,  CFG_FRAME_HEIGHT, 9'd0,   8'd0,   8'd0,   32'h0,         63'd0, 1'b0},
        '{ROW_CHECK, CFG_FRAME_WIDTH,  9'd0,   8'd0,   8'd0,   32'h0, 63'h3FFF_FFFF_0000_0001, 1'b0},
        '{ROW_CHECK, CFG_FRAME_WIDTH,  9'd0,   8'd0,   8'd1,   32'h0,         63'd0, 1'b1},
        '{ROW_LOAD,  CFG_FRAME_WIDTH,  9'd0,   8'd3,   8'd0,   32'd55,        63'd0, 1'b0},
        '{ROW_CHECK, CFG_FRAME_WIDTH,  9'd0,   8'd3,   8'd0,   32'h0,         63'd0, 1'b1},
        '{ROW_SIZE,  CFG_FRAME_WIDTH,  9'd511, 8'd0,   8'd0,   32'h0,         63'd0, 1'b0},
        '{ROW_CHECK, CFG_FRAME_WIDTH,  9'd0,   8'd255, 8'd255, 32'h0,         63'd0, 1'b1},
        '{ROW_CHECK, CFG_FRAME_WIDTH,  9'd0,   8'd0,   8'd251, 32'h0,         63'd26, 1'b0},
        '{ROW_SIZE,  CFG_FRAME_WIDTH,  9'd3,   8'd0,   8'd0,   32'h0,         63'd0, 1'b0},
        '{ROW_SIZE,  CFG_FRAME_HEIGHT, 9'd300, 8'd0,   8'd0,   32'h0,         63'd0, 1'b0},
        '{ROW_CHECK, CFG_FRAME_WIDTH,  9'd0,   8'd0,   8'd3,   32'h0,         63'd0, 1'b1},
        '{ROW_LOAD,  CFG_FRAME_WIDTH,  9'd0,   8'd255, 8'd2,   32'hFFFF_0000, 63'd0, 1'b0},
        '{ROW_QUERY, CFG_FRAME_WIDTH,  9'd0,   8'd255, 8'd2,   32'h1234_5678, 63'd0, 1'b0},
        '{ROW_SIZE,  CFG_FRAME_WIDTH,  9'd256, 8'd0,   8'd0,   32'h0,         63'd0, 1'b0},
        '{ROW_SIZE,  CFG_FRAME_HEIGHT, 9'd256, 8'd0,   8'd0,   32'h0,         63'd0, 1'b0}
    };

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = CFG_FRAME_WIDTH;
    logic [SIZE_W-1:0]  cfg_data  = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [47:0]        s_tdata   = '0;   // row_index, col_index, coefficient
    logic               s_tuser   = OP_LOAD;   // operation
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [63:0]        m_tdata;          // power, zero pad
    logic               m_tuser;          // index_error

    logic [COEF_W-1:0]  frame_coefs [0:FRAME_MAX*FRAME_MAX-1];
    bit                 written_map [0:FRAME_MAX*FRAME_MAX-1];
    logic [15:0]        written_list[$];
    logic [SIZE_W-1:0]  width_reg  = 9'd256;
    logic [SIZE_W-1:0]  height_reg = 9'd256;
    spectrum_t          pending_spectrum[$];
    spectrum_t          spectrum_want;

    int unsigned failures        = 0;
    int unsigned results_checked = 0;
    int unsigned size_writes     = 0;
    int unsigned random_items    = 0;
    int unsigned stalled_cycles  = 0;
    int unsigned longest_hold    = 0;
    bit          hold_req  = 1'b0;
    bit          hold_done = 1'b0;
    bit          calm      = 1'b0;

    hartley_power_spectrum_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic int unsigned eff_size(logic [SIZE_W-1:0] v);
        if (v == 0) return 1;
        if (v > FRAME_MAX) return FRAME_MAX;
        return 32'(v);
    endfunction

    function automatic logic [63:0] square_of(logic [COEF_W-1:0] w);
        logic signed [63:0] v;
        v = {{32{w[COEF_W-1]}}, w};
        return v * v;
    endfunction

    function automatic spectrum_t compute_power(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col);
        int unsigned w;
        int unsigned h;
        int unsigned mr;
        int unsigned mc;
        logic [63:0] sum;
        spectrum_t   res;
        w = eff_size(width_reg);
        h = eff_size(height_reg);
        res = '0;
        if (row >= h || col >= w) begin
            res.index_error = 1'b1;
            return res;
        end
        mr  = (row == 0) ? 0 : h - row;
        mc  = (col == 0) ? 0 : w - col;
        sum = square_of(frame_coefs[{row, col}]) + square_of(frame_coefs[mr * FRAME_MAX + mc]);
        res.power = sum[63:1];
        return res;
    endfunction

    function automatic logic [COEF_W-1:0] pick_coefficient();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return 32'hFFFF_FFFF;
            4: return 32'($urandom_range(511)) - 32'd256;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] pick_index(int unsigned n);
        case ($urandom_range(3))
            0: return '0;
            1: return IDX_W'(n - 1);
            default: return IDX_W'($urandom_range(n - 1));
        endcase
    endfunction

    task automatic offer_item(hps_op_t op, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                              logic [COEF_W-1:0] coef, bit typed = 1'b0,
                              spectrum_t typed_res = '0);
        if (!calm && $urandom_range(99) < 28) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < 28) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {coef, col, row};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (op == OP_LOAD) begin
            if (row < eff_size(height_reg) && col < eff_size(width_reg)) begin
                frame_coefs[{row, col}] = coef;
                if (!written_map[{row, col}]) begin
                    written_map[{row, col}] = 1'b1;
                    written_list.push_back({row, col});
                end
            end
        end else begin
            pending_spectrum.push_back(typed ? typed_res : compute_power(row, col));
        end
    endtask

    task automatic write_size(hps_cfg_idx_t sel, logic [SIZE_W-1:0] value);
        s_tvalid <= 1'b0;
        while (pending_spectrum.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (sel == CFG_FRAME_WIDTH) width_reg = value;
        else height_reg = value;
        size_writes++;
    endtask

    task automatic random_load();
        offer_item(OP_LOAD, pick_index(eff_size(height_reg)), pick_index(eff_size(width_reg)),
                   pick_coefficient());
    endtask

    // receiver: random back-pressure, one long hold-off, calm stretch
    initial begin : receiver
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
                longest_hold++;
            end else if (calm) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 28);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_spectrum.size() == 0) begin
                $error("result transfer with nothing expected: power %0d index_error %0b",
                       m_tdata[POWER_W-1:0], m_tuser);
                failures++;
            end else begin
                spectrum_want = pending_spectrum.pop_front();
                results_checked++;
                if (m_tdata[POWER_W-1:0] !== spectrum_want.power) begin
                    $error("power: expected %0d, actual %0d",
                           spectrum_want.power, m_tdata[POWER_W-1:0]);
                    failures++;
                end
                if (m_tuser !== spectrum_want.index_error) begin
                    $error("index_error: expected %0b, actual %0b",
                           spectrum_want.index_error, m_tuser);
                    failures++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            stalled_cycles <= 0;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
            if (stalled_cycles >= STALL_LIMIT) begin
                $display("** hartley_power_spectrum_top: FAILED **");
                $finish;
            end
        end
    end

    initial begin : stimulus
        stim_row_t         entry;
        spectrum_t         typed_res;
        int unsigned       phase;
        int unsigned       w;
        int unsigned       h;
        int unsigned       pick;
        logic [SIZE_W-1:0] new_w;
        logic [SIZE_W-1:0] new_h;
        logic [15:0]       addr;
        logic [IDX_W-1:0]  r;
        logic [IDX_W-1:0]  c;
        logic [IDX_W-1:0]  mr;
        logic [IDX_W-1:0]  mc;
        bit                found;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            entry = DIRECTED[i];
            case (entry.kind)
                ROW_SIZE:  write_size(entry.reg_sel, entry.size);
                ROW_LOAD:  offer_item(OP_LOAD, entry.row, entry.col, entry.coef);
                ROW_QUERY: offer_item(OP_QUERY, entry.row, entry.col, entry.coef);
                default: begin
                    typed_res.power       = entry.power;
                    typed_res.index_error = entry.index_error;
                    offer_item(OP_QUERY, entry.row, entry.col, entry.coef, 1'b1, typed_res);
                end
            endcase
        end

        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            case (phase)
                0: begin new_w = 9'd256; new_h = 9'd256; end
                1: begin new_w = 9'd0;   new_h = 9'd0;   end
                2: begin new_w = 9'd511; new_h = 9'd1;   end
                3: begin new_w = 9'd1;   new_h = 9'd300; end
                4: begin new_w = 9'd256; new_h = 9'd2;   end
                default: begin
                    if ($urandom_range(3) == 0) begin
                        new_w = SIZE_W'($urandom_range(511));
                        new_h = SIZE_W'($urandom_range(511));
                    end else begin
                        new_w = SIZE_W'($urandom_range(16, 1));
                        new_h = SIZE_W'($urandom_range(16, 1));
                    end
                end
            endcase
            write_size(CFG_FRAME_WIDTH, new_w);
            write_size(CFG_FRAME_HEIGHT, new_h);
            w = eff_size(width_reg);
            h = eff_size(height_reg);

            repeat (40) begin
                if (random_items >= 200) hold_req = 1'b1;
                calm = (random_items >= 320 && random_items < 400);
                pick = $urandom_range(99);
                if (pick >= 88 && (w < FRAME_MAX || h < FRAME_MAX)) begin
                    // out-of-range row or column
                    if (h < FRAME_MAX && (w == FRAME_MAX || $urandom_range(1) == 1)) begin
                        r = IDX_W'($urandom_range(255, h));
                        c = IDX_W'($urandom_range(255));
                    end else begin
                        r = IDX_W'($urandom_range(255));
                        c = IDX_W'($urandom_range(255, w));
                    end
                    offer_item(($urandom_range(1) == 1) ? OP_QUERY : OP_LOAD, r, c, $urandom);
                end else if (pick < 45) begin
                    random_load();
                    random_items++;
                end else begin
                    found = 1'b0;
                    for (int t = 0; t < 8 && !found; t++) begin
                        addr = written_list[$urandom_range(written_list.size() - 1)];
                        found = (addr[15:8] < h) && (addr[7:0] < w);
                    end
                    if (!found) begin
                        random_load();
                        random_items++;
                    end else begin
                        r  = addr[15:8];
                        c  = addr[7:0];
                        mr = (r == 0) ? '0 : IDX_W'(h - r);
                        mc = (c == 0) ? '0 : IDX_W'(w - c);
                        if (!written_map[{mr, mc}]) begin
                            offer_item(OP_LOAD, mr, mc, pick_coefficient());
                            random_items++;
                        end
                        offer_item(OP_QUERY, r, c, $urandom);
                        random_items++;
                    end
                end
            end
            phase++;
        end

        calm = 1'b0;
        s_tvalid <= 1'b0;
        while (pending_spectrum.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d directed rows and %0d random items over %0d size phases",
                 N_DIRECTED, random_items, phase);
        $display("checked %0d results, %0d size writes, receiver hold-off of %0d cycles",
                 results_checked, size_writes, longest_hold);
        if (failures == 0) begin
            $display("** hartley_power_spectrum_top: PASSED **");
        end else begin
            $display("** hartley_power_spectrum_top: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
hw/rtl/hps_pkg.sv
hw/rtl/hps_fifo.sv
hw/rtl/hps_front.sv
hw/rtl/hps_back.sv
hw/rtl/hartley_power_spectrum_top.sv
bench/tb_top.sv
